// ===== design/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error(msg);

`endif

// ===== design/ipv4v_pkg.sv =====
// ----------------------------------------------------------------------------
// ipv4v_pkg
// types and constants of the ipv4 literal validator
// ----------------------------------------------------------------------------
`default_nettype none

package ipv4v_pkg;

  typedef struct packed {
    logic [7:0] char_code;
    logic       has_char;
    logic       last;
  } char_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] address;
  } result_t;

  // character classes
  localparam logic [2:0] CLS_NONE  = 3'd0;
  localparam logic [2:0] CLS_WS    = 3'd1;
  localparam logic [2:0] CLS_DIGIT = 3'd2;
  localparam logic [2:0] CLS_DOT   = 3'd3;
  localparam logic [2:0] CLS_OTHER = 3'd4;

  typedef struct packed {
    logic [2:0] cls;
    logic [3:0] digit;
    logic       last;
  } token_t;

  // parse phases
  localparam logic [2:0] PH_LEAD = 3'd0;
  localparam logic [2:0] PH_BODY = 3'd1;
  localparam logic [2:0] PH_FAIL = 3'd2;

  // result status codes
  localparam logic [1:0] ST_VALID    = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_NOT_IPV4 = 2'd2;
  localparam logic [1:0] ST_NOT_LOCAL = 2'd3;

  localparam logic [7:0] CHAR_DOT  = 8'h2e;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  localparam logic [2:0] LAST_DOT_COUNT = 3'd3;
  localparam logic [11:0] OCTET_MAX = 12'd255;

endpackage

`default_nettype wire

// ===== design/ipv4v_front.sv =====
// ----------------------------------------------------------------------------
// ipv4v_front
// classifies one incoming character into a parse token
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4v_front (
  input  ipv4v_pkg::char_item_t item,
  output ipv4v_pkg::token_t     token
);
  import ipv4v_pkg::*;

  logic [7:0] c;
  logic [7:0] digit_full;

  assign c          = item.char_code;
  assign digit_full = c - CHAR_ZERO;

  always_comb begin
    token.last  = item.last;
    token.digit = digit_full[3:0];
    if (!item.has_char) begin
      token.cls = CLS_NONE;
    end else if (c inside {[8'd9:8'd13], 8'd32}) begin
      token.cls = CLS_WS;
    end else if (c inside {[CHAR_ZERO:CHAR_NINE]}) begin
      token.cls = CLS_DIGIT;
    end else if (c == CHAR_DOT) begin
      token.cls = CLS_DOT;
    end else begin
      token.cls = CLS_OTHER;
    end
  end

endmodule

`default_nettype wire

// ===== design/ipv4v_queue.sv =====
// ----------------------------------------------------------------------------
// ipv4v_queue
// two-entry token queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4v_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ipv4v_pkg::token_t push_token,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output ipv4v_pkg::token_t pop_token
);
  import ipv4v_pkg::*;

  token_t     mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_token = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_token;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/ipv4v_back.sv =====
// ----------------------------------------------------------------------------
// ipv4v_back
// parse state machine and result register
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4v_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               tok_valid,
  input  ipv4v_pkg::token_t  tok,
  output logic               tok_take,
  output logic               result_valid,
  input  logic               result_stall,
  output ipv4v_pkg::result_t result_data
);
  import ipv4v_pkg::*;

  logic [2:0]  phase, phase_next;
  logic [2:0]  octet_count, octet_count_next;
  logic [7:0]  digit_value, digit_value_next;
  logic        digit_seen, digit_seen_next;
  logic [23:0] done_octets, done_octets_next;
  logic        pending_space, pending_space_next;
  logic [11:0] scaled;
  logic [31:0] addr;
  logic        is_local;
  result_t     res_next;
  logic        out_free;

  assign out_free = !result_valid || !result_stall;
  assign tok_take = tok_valid && (!tok.last || out_free);

  // running octet value times ten plus the new digit
  assign scaled = {1'b0, digit_value, 3'b000} + {3'b000, digit_value, 1'b0}
                + {8'd0, tok.digit};

  always_comb begin
    phase_next         = phase;
    octet_count_next   = octet_count;
    digit_value_next   = digit_value;
    digit_seen_next    = digit_seen;
    done_octets_next   = done_octets;
    pending_space_next = pending_space;
    if (phase != PH_FAIL) begin
      case (tok.cls)
        CLS_NONE: begin
        end
        CLS_WS: begin
          if (phase == PH_BODY) begin
            pending_space_next = 1'b1;
          end
        end
        default: begin
          phase_next = PH_BODY;
          if (pending_space) begin
            phase_next = PH_FAIL;
          end else if (tok.cls == CLS_DIGIT) begin
            if (scaled > OCTET_MAX) begin
              phase_next = PH_FAIL;
            end else begin
              digit_value_next = scaled[7:0];
              digit_seen_next  = 1'b1;
            end
          end else if (tok.cls == CLS_DOT) begin
            if (!digit_seen || octet_count >= LAST_DOT_COUNT) begin
              phase_next = PH_FAIL;
            end else begin
              done_octets_next = {done_octets[15:0], digit_value};
              octet_count_next = octet_count + 3'd1;
              digit_value_next = 8'd0;
              digit_seen_next  = 1'b0;
            end
          end else begin
            phase_next = PH_FAIL;
          end
        end
      endcase
    end
  end

  assign addr = {done_octets_next, digit_value_next};

  // loopback and private ranges
  always_comb begin
    is_local = (addr[31:24] == 8'd127) || (addr[31:24] == 8'd10)
            || (addr[31:24] == 8'd172 && addr[23:16] inside {[8'd16:8'd31]})
            || (addr[31:24] == 8'd192 && addr[23:16] == 8'd168);
  end

  always_comb begin
    res_next.address = 32'd0;
    if (phase_next == PH_LEAD) begin
      res_next.status = ST_EMPTY;
    end else if (phase_next == PH_FAIL || octet_count_next != LAST_DOT_COUNT
                 || !digit_seen_next) begin
      res_next.status = ST_NOT_IPV4;
    end else if (is_local) begin
      res_next.status  = ST_VALID;
      res_next.address = addr;
    end else begin
      res_next.status = ST_NOT_LOCAL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_LEAD;
      octet_count   <= 3'd0;
      digit_value   <= 8'd0;
      digit_seen    <= 1'b0;
      done_octets   <= 24'd0;
      pending_space <= 1'b0;
    end else if (tok_take) begin
      if (tok.last) begin
        phase         <= PH_LEAD;
        octet_count   <= 3'd0;
        digit_value   <= 8'd0;
        digit_seen    <= 1'b0;
        done_octets   <= 24'd0;
        pending_space <= 1'b0;
      end else begin
        phase         <= phase_next;
        octet_count   <= octet_count_next;
        digit_value   <= digit_value_next;
        digit_seen    <= digit_seen_next;
        done_octets   <= done_octets_next;
        pending_space <= pending_space_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (tok_take && tok.last) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_take && tok.last) begin
      result_data <= res_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/ipv4_literal_validator.sv =====
// ----------------------------------------------------------------------------
// ipv4_literal_validator
// checks a host string for a loopback or private dotted-decimal ipv4 address
// ----------------------------------------------------------------------------
// usage
//   char channel: one character per transfer (char_valid, char_stall,
//   char_data); has_char low marks an item with no character, last marks
//   the end of the string
//   result channel: one transfer per string, issued for the item with last
//   set; status plus the packed address (zero unless status is valid)
//   result timing: a result is presented the cycle after its last character
//   leaves the queue, and each character first passes the queue register
//   throughput: one character per cycle while char_stall is low; the parse
//   state update is a registered step in the back end
//   a two-entry token queue sits between the classifier and the parser;
//   char_stall rises only when that queue is full
//   while result_valid and result_stall are high the result register holds;
//   characters without last keep flowing, a last character waits in the queue
//   reset: queue emptied, parse state back to leading whitespace, no result
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_literal_validator (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  char_valid,
  output logic                  char_stall,
  input  ipv4v_pkg::char_item_t char_data,
  output logic                  result_valid,
  input  logic                  result_stall,
  output ipv4v_pkg::result_t    result_data
);
  import ipv4v_pkg::*;

  `include "assert_macros.svh"

  token_t front_token;
  token_t queue_token;
  logic   queue_full;
  logic   queue_not_empty;
  logic   back_take;

  // character classification
  ipv4v_front u_front (
    .item  (char_data),
    .token (front_token)
  );

  // decoupling queue
  ipv4v_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (char_valid),
    .push_token (front_token),
    .full       (queue_full),
    .pop        (back_take),
    .not_empty  (queue_not_empty),
    .pop_token  (queue_token)
  );

  assign char_stall = queue_full;

  // parser and result register
  ipv4v_back u_back (
    .clk          (clk),
    .rst          (rst),
    .tok_valid    (queue_not_empty),
    .tok          (queue_token),
    .tok_take     (back_take),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

  // assertions
  `ASSERT_IMPLIES(a_addr_zero, clk, rst,
    result_valid && result_data.status != ST_VALID,
    result_data.address == 32'd0, "address not zero on a failed result")
  `ASSERT_IMPLIES(a_addr_local, clk, rst,
    result_valid && result_data.status == ST_VALID,
    result_data.address[31:24] == 8'd127 || result_data.address[31:24] == 8'd10
      || result_data.address[31:24] == 8'd172 || result_data.address[31:24] == 8'd192,
    "valid result outside local ranges")
  `ASSERT_IMPLIES(a_reset_idle, clk, rst, $past(rst), !result_valid,
    "result valid right after reset")
  `ASSERT_NEXT(a_take_needs_token, clk, rst, !queue_not_empty && !char_valid,
    !back_take, "parser took a token from an empty queue")

endmodule

`default_nettype wire
